### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL, included by the modulator top.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define ASSERT_SAME_CYCLE(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequence must hold in the cycle after the condition.
`define ASSERT_NEXT_CYCLE(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

### hw/rtl/afsk_pkg.sv
package afsk_pkg;

    // Item operation codes.
    typedef enum logic [2:0] {
        OP_WRITE_BYTE  = 3'd0,
        OP_WRITE_WAVE  = 3'd1,
        OP_START_FRAME = 3'd2,
        OP_START_TEST  = 3'd3,
        OP_TICK        = 3'd4
    } t_op;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PACKET_BITS     = 3'd0;
    localparam logic [2:0] CFG_SAMPLES_PER_BIT = 3'd1;
    localparam logic [2:0] CFG_MARK_STEP       = 3'd2;
    localparam logic [2:0] CFG_SPACE_STEP      = 3'd3;
    localparam logic [2:0] CFG_REST_LEVEL      = 3'd4;

    // Configuration reset values.
    localparam logic [11:0] RST_PACKET_BITS     = 12'd0;
    localparam logic [7:0]  RST_SAMPLES_PER_BIT = 8'd52;
    localparam logic [15:0] RST_MARK_STEP       = 16'd1258;
    localparam logic [15:0] RST_SPACE_STEP      = 16'd2306;
    localparam logic [7:0]  RST_REST_LEVEL      = 8'd127;

    localparam int PACKET_BYTES_DEF = 256;
    localparam int WAVE_ENTRIES     = 512;
    localparam int WAVE_AW          = 9;
    // The wave table index is the phase with its 7 fractional bits dropped.
    localparam int PHASE_FRAC       = 7;

endpackage

### hw/rtl/afsk_ram.sv
module afsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/afsk_nrzi_tone_modulator_top.sv
// An accepted item passes through the input register and then the result register, where its result is valid.
// Throughput: one item per cycle; the block takes a new item in every cycle the result side is not stalled.
// The wave table lookup uses the registered read port of the wave memory as the result stage.
// Reset is synchronous and active low: it clears all control state and loads the register defaults.
// The packet and wave memories are not cleared by reset and must be written before they are read.
`include "assert_macros.svh"

module afsk_nrzi_tone_modulator_top
    import afsk_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Input item channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_operation,
    input  logic [8:0]  i_location,
    input  logic [7:0]  i_write_value,
    // Result item channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_sample_level,
    output logic        o_transmit_key,
    output logic        o_busy_res,
    output logic        o_finished
);

    // The packet memory address covers PACKET_BYTES; a byte index is 9 bits and is
    // widened to 13 bits so it can be compared with any depth up to 8191.
    localparam int          PKT_AW    = $clog2(PACKET_BYTES);
    localparam logic [12:0] PKT_LIMIT = 13'(PACKET_BYTES);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [11:0] r_cfg_packet_bits;
    logic [7:0]  r_cfg_spb;
    logic [15:0] r_cfg_mark;
    logic [15:0] r_cfg_space;
    logic [7:0]  r_cfg_rest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_packet_bits <= RST_PACKET_BITS;
            r_cfg_spb         <= RST_SAMPLES_PER_BIT;
            r_cfg_mark        <= RST_MARK_STEP;
            r_cfg_space       <= RST_SPACE_STEP;
            r_cfg_rest        <= RST_REST_LEVEL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PACKET_BITS:     r_cfg_packet_bits <= i_cfg_data[11:0];
                CFG_SAMPLES_PER_BIT: r_cfg_spb         <= i_cfg_data[7:0];
                CFG_MARK_STEP:       r_cfg_mark        <= i_cfg_data;
                CFG_SPACE_STEP:      r_cfg_space       <= i_cfg_data;
                CFG_REST_LEVEL:      r_cfg_rest        <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The input register advances into the result register
    // whenever the result register is empty or being taken this cycle.
    // ------------------------------------------------------------------
    logic r_in_valid;
    t_op  r_op;
    logic [8:0] r_loc;
    logic [7:0] r_val;
    logic r_out_valid;
    logic adv;
    logic in_acc;

    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op  <= t_op'(i_operation);
            r_loc <= i_location;
            r_val <= i_write_value;
        end
    end

    // ------------------------------------------------------------------
    // Modulator state
    // ------------------------------------------------------------------
    logic [15:0] r_phase_acc,  n_phase_acc;
    logic [15:0] r_phase_step, n_phase_step;
    logic [11:0] r_bit_pos,    n_bit_pos;
    logic [7:0]  r_tick,       n_tick;
    logic        r_sending,    n_sending;
    logic        r_testing,    n_testing;
    logic [8:0]  r_saw_level,  n_saw_level;
    logic [8:0]  r_saw_step,   n_saw_step;
    logic [7:0]  r_level,      n_level;
    // When set, the held output level is the last sample read from the wave
    // memory, which its read register keeps until the next sample tick.
    logic        r_lvl_wave,   n_lvl_wave;
    logic        r_key,        n_key;
    logic        n_finished;

    // Memory controls.
    logic             pkt_we;
    logic             wave_we;
    logic             wave_re;
    logic [7:0]       pkt_q;
    logic [7:0]       wave_q;
    logic [8:0]       n_byte_ix;
    logic [12:0]      pkt_rd_ext;
    logic [12:0]      pkt_wr_ext;
    logic [PKT_AW-1:0] pkt_raddr;
    logic [PKT_AW-1:0] pkt_waddr;
    logic             loc_in_range;

    // The packet memory is read continuously at the byte that holds the next
    // bit position, so the byte is ready when the following item arrives. A
    // write to that same byte in the same cycle is forwarded past the memory.
    logic       r_pkt_fwd;
    logic [7:0] r_pkt_fwd_data;
    logic       r_pkt_oor;
    logic [7:0] cur_byte;
    logic       frame_bit;

    assign pkt_wr_ext   = {4'd0, r_loc};
    assign loc_in_range = pkt_wr_ext < PKT_LIMIT;
    assign pkt_waddr    = pkt_wr_ext[PKT_AW-1:0];
    assign n_byte_ix    = n_bit_pos[11:3];
    assign pkt_rd_ext   = {4'd0, n_byte_ix};
    assign pkt_raddr    = pkt_rd_ext[PKT_AW-1:0];

    assign cur_byte  = r_pkt_fwd ? r_pkt_fwd_data : pkt_q;
    assign frame_bit = !r_pkt_oor && cur_byte[r_bit_pos[2:0]];

    // Frame tick arithmetic. A zero bit at the start of a bit period swaps
    // the step between the mark and space values (NRZI).
    logic        frame_end;
    logic        swap_step;
    logic [15:0] step_next;
    logic [15:0] phase_sum;
    logic [7:0]  tick_inc;

    assign frame_end = r_bit_pos >= r_cfg_packet_bits;
    assign swap_step = (r_tick == 8'd0) && !frame_bit;
    assign step_next = swap_step ? (r_phase_step ^ (r_cfg_mark ^ r_cfg_space)) : r_phase_step;
    assign phase_sum = r_phase_acc + step_next;
    assign tick_inc  = r_tick + 8'd1;

    // Test sweep arithmetic. When the sawtooth passes 255 it restarts at zero
    // with a step one larger; a step beyond 255 ends the sweep.
    logic [8:0] saw_base;
    logic [8:0] saw_step_eff;

    assign saw_base     = r_saw_level[8] ? 9'd0 : r_saw_level;
    assign saw_step_eff = r_saw_level[8] ? (r_saw_step + 9'd1) : r_saw_step;

    always_comb begin
        n_phase_acc  = r_phase_acc;
        n_phase_step = r_phase_step;
        n_bit_pos    = r_bit_pos;
        n_tick       = r_tick;
        n_sending    = r_sending;
        n_testing    = r_testing;
        n_saw_level  = r_saw_level;
        n_saw_step   = r_saw_step;
        n_level      = r_level;
        n_lvl_wave   = r_lvl_wave;
        n_key        = r_key;
        n_finished   = 1'b0;
        pkt_we       = 1'b0;
        wave_we      = 1'b0;
        wave_re      = 1'b0;
        if (adv) begin
            case (r_op)
                OP_WRITE_BYTE: begin
                    pkt_we = loc_in_range;
                end
                OP_WRITE_WAVE: begin
                    wave_we = 1'b1;
                end
                OP_START_FRAME: begin
                    n_phase_step = r_cfg_mark;
                    n_phase_acc  = 16'd0;
                    n_bit_pos    = 12'd0;
                    n_tick       = 8'd0;
                    n_sending    = 1'b1;
                    n_key        = 1'b1;
                end
                OP_START_TEST: begin
                    n_saw_level = 9'd0;
                    n_saw_step  = 9'd1;
                    n_testing   = 1'b1;
                    n_key       = 1'b1;
                end
                OP_TICK: begin
                    if (r_sending) begin
                        if (frame_end) begin
                            // Frame over: back to the rest level, key released.
                            n_level    = r_cfg_rest;
                            n_lvl_wave = 1'b0;
                            n_key      = 1'b0;
                            n_sending  = 1'b0;
                            n_testing  = 1'b0;
                            n_finished = 1'b1;
                        end else begin
                            n_phase_step = step_next;
                            n_phase_acc  = phase_sum;
                            wave_re      = 1'b1;
                            n_lvl_wave   = 1'b1;
                            if (tick_inc == r_cfg_spb) begin
                                n_tick    = 8'd0;
                                n_bit_pos = r_bit_pos + 12'd1;
                            end else begin
                                n_tick = tick_inc;
                            end
                        end
                    end else if (r_testing) begin
                        if (r_saw_step[8]) begin
                            n_level     = r_cfg_rest;
                            n_lvl_wave  = 1'b0;
                            n_key       = 1'b0;
                            n_testing   = 1'b0;
                            n_saw_level = 9'd0;
                            n_finished  = 1'b1;
                        end else begin
                            n_saw_step  = saw_step_eff;
                            n_level     = saw_base[7:0];
                            n_lvl_wave  = 1'b0;
                            n_saw_level = saw_base + saw_step_eff;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc  <= 16'd0;
            r_phase_step <= 16'd0;
            r_bit_pos    <= 12'd0;
            r_tick       <= 8'd0;
            r_sending    <= 1'b0;
            r_testing    <= 1'b0;
            r_saw_level  <= 9'd0;
            r_saw_step   <= 9'd0;
            r_level      <= RST_REST_LEVEL;
            r_lvl_wave   <= 1'b0;
            r_key        <= 1'b0;
            r_pkt_fwd    <= 1'b0;
            r_pkt_oor    <= 1'b0;
        end else begin
            r_phase_acc  <= n_phase_acc;
            r_phase_step <= n_phase_step;
            r_bit_pos    <= n_bit_pos;
            r_tick       <= n_tick;
            r_sending    <= n_sending;
            r_testing    <= n_testing;
            r_saw_level  <= n_saw_level;
            r_saw_step   <= n_saw_step;
            r_level      <= n_level;
            r_lvl_wave   <= n_lvl_wave;
            r_key        <= n_key;
            r_pkt_fwd    <= pkt_we && (r_loc == n_byte_ix);
            r_pkt_oor    <= pkt_rd_ext >= PKT_LIMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pkt_fwd_data <= r_val;
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    afsk_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_BYTES)
    ) u_packet_ram (
        .i_clk   (i_clk),
        .i_we    (pkt_we),
        .i_waddr (pkt_waddr),
        .i_wdata (r_val),
        .i_re    (1'b1),
        .i_raddr (pkt_raddr),
        .o_rdata (pkt_q)
    );

    // The wave memory is only read on a sample tick, so its read register
    // keeps holding the current sample level between ticks.
    afsk_ram #(
        .WIDTH (8),
        .DEPTH (WAVE_ENTRIES)
    ) u_wave_ram (
        .i_clk   (i_clk),
        .i_we    (wave_we),
        .i_waddr (r_loc),
        .i_wdata (r_val),
        .i_re    (wave_re),
        .i_raddr (phase_sum[PHASE_FRAC +: WAVE_AW]),
        .o_rdata (wave_q)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic       r_out_lvl_wave;
    logic [7:0] r_out_level;
    logic       r_out_key;
    logic       r_out_busy;
    logic       r_out_finished;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_lvl_wave <= n_lvl_wave;
            r_out_level    <= n_level;
            r_out_key      <= n_key;
            r_out_busy     <= n_sending || n_testing;
            r_out_finished <= n_finished;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_level = r_out_lvl_wave ? wave_q : r_out_level;
    assign o_transmit_key = r_out_key;
    assign o_busy_res     = r_out_busy;
    assign o_finished     = r_out_finished;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_SAME_CYCLE(a_busy_keyed, i_clk, i_rst_n, o_out_valid && o_busy_res, o_transmit_key)
    `ASSERT_SAME_CYCLE(a_finish_idle, i_clk, i_rst_n, o_out_valid && o_finished, !o_busy_res)
    `ASSERT_SAME_CYCLE(a_wave_read_sending, i_clk, i_rst_n, wave_re, r_sending && !frame_end)
    `ASSERT_NEXT_CYCLE(a_adv_result, i_clk, i_rst_n, adv, o_out_valid)

endmodule

### tb/tb_afsk_nrzi_tone_modulator_top.sv
`timescale 1ns / 100ps

// Self-checking bench for the AFSK tone modulator with NRZI coding.
// Items go in through a valid/stall channel, and every item gives back one
// result item. A local copy of the modulator state predicts each result when its
// item is accepted. A checker compares every result that arrives against the
// oldest prediction still waiting.
module tb_afsk_nrzi_tone_modulator_top;
    import afsk_pkg::*;

    localparam int PACKET_DEPTH = PACKET_BYTES_DEF;
    // Two register stages sit between an accepted item and its result.
    localparam int RESULT_LATENCY = 2;
    localparam int SETTLE_CYCLES = RESULT_LATENCY + 4;
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST = 3'd7;
    localparam logic [2:0] CFG_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CFG_UNUSED_LAST = 3'd7;

    typedef struct packed {
        logic [7:0] level;
        logic       key;
        logic       busy;
        logic       done;
    } t_tone_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_operation;
    logic [8:0]  i_location;
    logic [7:0]  i_write_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_sample_level;
    logic        o_transmit_key;
    logic        o_busy_res;
    logic        o_finished;

    afsk_nrzi_tone_modulator_top #(
        .PACKET_BYTES(PACKET_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_location     (i_location),
        .i_write_value  (i_write_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_level (o_sample_level),
        .o_transmit_key (o_transmit_key),
        .o_busy_res     (o_busy_res),
        .o_finished     (o_finished)
    );

    // Local copy of the configuration registers.
    logic [11:0] reg_packet_bits;
    logic [7:0]  reg_samples_per_bit;
    logic [15:0] reg_mark_step;
    logic [15:0] reg_space_step;
    logic [7:0]  reg_rest_level;

    // Local copy of the modulator state.
    logic [7:0]  packet_copy [PACKET_DEPTH];
    logic [7:0]  wave_copy [WAVE_ENTRIES];
    logic [15:0] tone_phase;
    logic [15:0] tone_step;
    logic [11:0] bit_index;
    logic [7:0]  tick_count;
    logic        frame_on;
    logic        sweep_on;
    logic [8:0]  saw_value;
    logic [8:0]  saw_incr;
    logic [7:0]  held_level;
    logic        held_key;

    // Predicted results, oldest first.
    t_tone_result awaited_samples[$];

    int failures = 0;
    int items_sent = 0;
    int cycle_count = 0;
    int stall_left = 0;
    bit bursts_on = 1'b1;

    initial begin
        i_clk = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[afsk_nrzi_tone_modulator_top] ERROR");
            $finish;
        end
    end

    // The result side stalls in random bursts while bursts are enabled.
    always @(negedge i_clk) begin
        if (bursts_on && stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 9);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            failures++;
        end
    endtask

    // Outputs are sampled at the rising edge, before the block updates them.
    always @(posedge i_clk) begin : check_results
        t_tone_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_samples.size() == 0) begin
                $display("%0t: result with nothing awaited: expected none, got %0d/%0b/%0b/%0b",
                         $time, o_sample_level, o_transmit_key, o_busy_res, o_finished);
                failures++;
            end else begin
                want = awaited_samples.pop_front();
                compare_field("sample_level", want.level, o_sample_level);
                compare_field("transmit_key", 8'(want.key), 8'(o_transmit_key));
                compare_field("busy_res", 8'(want.busy), 8'(o_busy_res));
                compare_field("finished", 8'(want.done), 8'(o_finished));
            end
        end
    end

    // Ending a frame or a sweep returns the output to the rest level and drops the key.
    task automatic stop_tone();
        held_level = reg_rest_level;
        held_key = 1'b0;
        frame_on = 1'b0;
        sweep_on = 1'b0;
    endtask

    // Advances the local state by one accepted item and queues its result.
    task automatic predict_tone_sample(input logic [2:0] op, input logic [8:0] loc,
                                       input logic [7:0] val);
        t_tone_result r;
        logic done;
        logic coded_bit;
        done = 1'b0;
        case (op)
            OP_WRITE_BYTE: begin
                if (loc < PACKET_DEPTH) packet_copy[loc] = val;
            end
            OP_WRITE_WAVE: begin
                wave_copy[loc] = val;
            end
            OP_START_FRAME: begin
                tone_step = reg_mark_step;
                tone_phase = '0;
                bit_index = '0;
                tick_count = '0;
                frame_on = 1'b1;
                held_key = 1'b1;
            end
            OP_START_TEST: begin
                saw_value = '0;
                saw_incr = 9'd1;
                sweep_on = 1'b1;
                held_key = 1'b1;
            end
            OP_TICK: begin
                if (frame_on) begin
                    if (bit_index >= reg_packet_bits) begin
                        stop_tone();
                        done = 1'b1;
                    end else begin
                        // Bits past the end of the packet store read as zero.
                        coded_bit = ((bit_index >> 3) < PACKET_DEPTH) ?
                                    packet_copy[bit_index >> 3][bit_index[2:0]] : 1'b0;
                        // NRZI: a zero bit swaps between the mark and space tones.
                        if (tick_count == 8'd0 && !coded_bit)
                            tone_step = tone_step ^ (reg_mark_step ^ reg_space_step);
                        tone_phase = tone_phase + tone_step;
                        held_level = wave_copy[tone_phase[15:PHASE_FRAC]];
                        // The counter is 8 bits wide, so zero samples per bit means 256.
                        tick_count = tick_count + 8'd1;
                        if (tick_count == reg_samples_per_bit) begin
                            tick_count = '0;
                            bit_index = bit_index + 12'd1;
                        end
                    end
                end else if (sweep_on) begin
                    if (saw_incr > 9'd255) begin
                        stop_tone();
                        saw_value = '0;
                        done = 1'b1;
                    end else begin
                        if (saw_value > 9'd255) begin
                            saw_value = '0;
                            saw_incr = saw_incr + 9'd1;
                        end
                        held_level = saw_value[7:0];
                        saw_value = saw_value + saw_incr;
                    end
                end
            end
            default: begin
            end
        endcase
        r.level = held_level;
        r.key = held_key;
        r.busy = frame_on || sweep_on;
        r.done = done;
        awaited_samples.push_back(r);
    endtask

    // Sends one item, holding it until the block takes it. Within this task the valid
    // line is only lowered for an idle burst, never between two items sent back to back.
    task automatic send_item(input logic [2:0] op, input logic [8:0] loc,
                             input logic [7:0] val);
        @(negedge i_clk);
        if (bursts_on && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_location <= loc;
        i_write_value <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_tone_sample(op, loc, val);
        if (op <= OP_TICK) items_sent++;
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 9'($urandom), 8'($urandom));
    endtask

    // Waits until every predicted result has come back and the pipeline is empty.
    task automatic settle_block();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PACKET_BITS:     reg_packet_bits = data[11:0];
            CFG_SAMPLES_PER_BIT: reg_samples_per_bit = data[7:0];
            CFG_MARK_STEP:       reg_mark_step = data;
            CFG_SPACE_STEP:      reg_space_step = data;
            CFG_REST_LEVEL:      reg_rest_level = data[7:0];
            default: begin
            end
        endcase
    endtask

    // Writes all five registers. The unused upper data bits carry random junk.
    task automatic configure(input logic [11:0] pbits, input logic [7:0] spb,
                             input logic [15:0] mark, input logic [15:0] space,
                             input logic [7:0] rest);
        write_register(CFG_PACKET_BITS, {4'($urandom), pbits});
        write_register(CFG_SAMPLES_PER_BIT, {8'($urandom), spb});
        write_register(CFG_MARK_STEP, mark);
        write_register(CFG_SPACE_STEP, space);
        write_register(CFG_REST_LEVEL, {8'($urandom), rest});
    endtask

    task automatic tick_until_stopped();
        while (frame_on || sweep_on) send_tick();
    endtask

    function automatic logic [15:0] pick_step();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // One item that is not a tick: store writes anywhere in the location range,
    // unused operation codes, and the odd restart of a frame or a sweep.
    task automatic random_side_item();
        case ($urandom_range(0, 9))
            0, 1, 2: send_item(OP_WRITE_BYTE, 9'($urandom), 8'($urandom));
            3, 4, 5: send_item(OP_WRITE_WAVE, 9'($urandom), 8'($urandom));
            6, 7: send_item(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                            9'($urandom), 8'($urandom));
            8: send_item(OP_START_TEST, 9'($urandom), 8'($urandom));
            default: send_item(OP_START_FRAME, 9'($urandom), 8'($urandom));
        endcase
    endtask

    // Mostly short frames with random settings, run to their end with some noise
    // mixed in, some started over a sweep cut short; the rest is bare noise.
    task automatic random_scenario();
        int kind;
        int guard;
        logic [11:0] pbits;
        logic [7:0] spb;
        settle_block();
        if ($urandom_range(0, 2) != 0) begin
            pbits = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 24));
            spb = 8'($urandom_range(1, 5));
            // Zero samples per bit stretches each bit to 256 ticks: keep the frame short.
            if ($urandom_range(0, 11) == 0) begin
                spb = 8'd0;
                pbits = 12'd1;
            end
            configure(pbits, spb, pick_step(), pick_step(), 8'($urandom));
        end
        kind = $urandom_range(0, 9);
        if (kind >= 7 && kind <= 8) begin
            send_item(OP_START_TEST, 9'($urandom), 8'($urandom));
            repeat ($urandom_range(5, 40)) send_tick();
        end
        if (kind <= 8) begin
            send_item(OP_START_FRAME, 9'($urandom), 8'($urandom));
            guard = 0;
            while (frame_on && guard < 600) begin
                if ($urandom_range(0, 9) == 0) random_side_item();
                else send_tick();
                guard++;
            end
            repeat ($urandom_range(0, 2)) send_tick();
        end else begin
            repeat ($urandom_range(5, 15)) begin
                if ($urandom_range(0, 1) == 0) random_side_item();
                else send_tick();
            end
        end
    endtask

    // Ticks on an idle block, unused operation codes and register indexes, an
    // ignored packet write past the store, and a frame of zero bits that ends at
    // once. None of these reads a store, so they run before the tables are filled.
    task automatic test_idle_block();
        for (int idx = CFG_UNUSED_FIRST; idx <= CFG_UNUSED_LAST; idx++)
            write_register(3'(idx), 16'($urandom));
        send_tick();
        for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
            send_item(3'(op), 9'($urandom), 8'($urandom));
        send_item(OP_WRITE_BYTE, 9'h1FF, 8'hFF);
        send_item(OP_START_FRAME, 9'd0, 8'd0);
        send_tick();
        send_tick();
    endtask

    // A full sawtooth sweep, step 1 through 255, then one idle tick after it ends.
    task automatic test_full_sweep();
        settle_block();
        write_register(CFG_REST_LEVEL, 16'($urandom_range(1, 254)));
        send_item(OP_START_TEST, 9'd0, 8'd0);
        tick_until_stopped();
        send_tick();
    endtask

    // Every wave entry and packet byte is written before any frame reads one.
    task automatic load_tables();
        for (int i = 0; i < WAVE_ENTRIES; i++)
            send_item(OP_WRITE_WAVE, 9'(i), 8'($urandom));
        for (int i = 0; i < PACKET_DEPTH; i++) begin
            send_item(OP_WRITE_BYTE, 9'(i), 8'($urandom));
            if (i % 64 == 0) send_item(OP_WRITE_BYTE, 9'($urandom_range(PACKET_DEPTH, 511)),
                                       8'($urandom));
        end
        // A fixed pattern at the head of the packet mixes zero and one bits early.
        send_item(OP_WRITE_BYTE, 9'd0, 8'hA5);
        send_item(OP_WRITE_WAVE, 9'd0, 8'h00);
        send_item(OP_WRITE_WAVE, 9'h1FF, 8'hFF);
    endtask

    // Register extremes: zero and full-scale steps, rest levels at both ends,
    // one and 255 samples per bit, and zero samples per bit.
    task automatic test_register_extremes();
        settle_block();
        configure(12'd2, 8'd1, 16'h0000, 16'hFFFF, 8'd0);
        send_item(OP_START_FRAME, 9'd0, 8'd0);
        tick_until_stopped();
        settle_block();
        configure(12'd1, 8'd255, 16'hFFFF, 16'h0000, 8'd255);
        send_item(OP_START_FRAME, 9'd0, 8'd0);
        tick_until_stopped();
        settle_block();
        configure(12'd1, 8'd0, RST_MARK_STEP, RST_SPACE_STEP, RST_REST_LEVEL);
        send_item(OP_START_FRAME, 9'd0, 8'd0);
        tick_until_stopped();
    endtask

    // A frame started under a running sweep wins and its end clears both; a sweep started
    // under a frame never runs: the frame's end clears it; a second frame start restarts.
    task automatic test_frame_over_sweep();
        settle_block();
        configure(12'd3, 8'd2, 16'($urandom), 16'($urandom), 8'($urandom));
        send_item(OP_START_TEST, 9'd0, 8'd0);
        repeat (5) send_tick();
        send_item(OP_START_FRAME, 9'd0, 8'd0);
        tick_until_stopped();
        send_tick();
        send_item(OP_START_FRAME, 9'd0, 8'd0);
        repeat (3) send_tick();
        send_item(OP_START_TEST, 9'd0, 8'd0);
        repeat (2) send_tick();
        send_item(OP_START_FRAME, 9'd0, 8'd0);
        tick_until_stopped();
        send_tick();
    endtask

    // A long frame: all 2048 bits of the packet store and 8 more past its end.
    task automatic test_long_frame();
        settle_block();
        configure(12'd2056, 8'd1, 16'($urandom), 16'($urandom), 8'($urandom));
        send_item(OP_START_FRAME, 9'd0, 8'd0);
        tick_until_stopped();
    endtask

    task automatic test_random_mix();
        int first;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            bursts_on = ($urandom_range(0, 3) != 0);
            random_scenario();
        end
    endtask

    // The tail of the run streams with no random idle bursts or result stalls.
    task automatic test_steady_flow();
        bursts_on = 1'b0;
        repeat (2) random_scenario();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_PACKET_BITS;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_operation = OP_TICK;
        i_location = '0;
        i_write_value = '0;
        i_out_stall = 1'b0;

        reg_packet_bits = RST_PACKET_BITS;
        reg_samples_per_bit = RST_SAMPLES_PER_BIT;
        reg_mark_step = RST_MARK_STEP;
        reg_space_step = RST_SPACE_STEP;
        reg_rest_level = RST_REST_LEVEL;
        foreach (packet_copy[i]) packet_copy[i] = '0;
        foreach (wave_copy[i]) wave_copy[i] = '0;
        tone_phase = '0;
        tone_step = '0;
        bit_index = '0;
        tick_count = '0;
        frame_on = 1'b0;
        sweep_on = 1'b0;
        saw_value = '0;
        saw_incr = '0;
        held_level = RST_REST_LEVEL;
        held_key = 1'b0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_block();
        test_full_sweep();
        load_tables();
        test_register_extremes();
        test_frame_over_sweep();
        test_long_frame();
        test_random_mix();
        test_steady_flow();

        settle_block();
        if (failures == 0) begin
            $display("[afsk_nrzi_tone_modulator_top] OK");
        end else begin
            $display("[afsk_nrzi_tone_modulator_top] ERROR");
        end
        $finish;
    end

endmodule
